FILE: design/qslc_pkg.sv
// shared types and constants of the quicksort unit with operation counts
package qslc_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int VALUE_W          = 32;
    localparam int WIDE_W           = 64;
    localparam int COUNT_W          = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_set;
        logic [COUNT_W-1:0]        comparisons;
        logic [COUNT_W-1:0]        swaps;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stack_cmd;

    typedef struct packed {
        logic clear;
        logic cmp_inc;
        logic swap_inc;
    } t_count_cmd;

endpackage

FILE: design/qslc_stack.sv
// range stack: memory of pending (low, high) pairs and its pointer
module qslc_stack #(
    parameter int DEPTH = qslc_pkg::MAX_ELEMENTS_DEF,
    parameter int IDX_W = $clog2(qslc_pkg::MAX_ELEMENTS_DEF)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qslc_pkg::t_stack_cmd  i_cmd,
    input  logic [IDX_W-1:0]      i_lo,
    input  logic [IDX_W-1:0]      i_hi,
    output logic [IDX_W-1:0]      o_lo,
    output logic [IDX_W-1:0]      o_hi,
    output logic                  o_empty
);

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int SIDX_W = $clog2(DEPTH);

    logic [2*IDX_W-1:0] r_mem [DEPTH];
    logic [2*IDX_W-1:0] r_rd;
    logic [PTR_W-1:0]   r_sp;
    logic [PTR_W-1:0]   n_sp;
    logic [PTR_W-1:0]   w_base;
    logic [PTR_W-1:0]   w_pop_ptr;
    logic               w_we;

    assign w_base    = i_cmd.clear ? '0 : r_sp;
    assign w_pop_ptr = r_sp - PTR_W'(1);
    assign w_we      = i_cmd.push && (w_base < PTR_W'(DEPTH));

    always_comb begin
        n_sp = w_base;
        if (w_we) begin
            n_sp = w_base + PTR_W'(1);
        end else if (i_cmd.pop && !i_cmd.clear) begin
            n_sp = w_pop_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_base[SIDX_W-1:0]] <= {i_lo, i_hi};
        end
        r_rd <= r_mem[w_pop_ptr[SIDX_W-1:0]];
    end

    assign o_lo    = r_rd[2*IDX_W-1:IDX_W];
    assign o_hi    = r_rd[IDX_W-1:0];
    assign o_empty = (r_sp == '0);

endmodule

FILE: design/qslc_counts.sv
// saturating comparison and swap totals
module qslc_counts (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qslc_pkg::t_count_cmd            i_cmd,
    output logic [qslc_pkg::COUNT_W-1:0]    o_comparisons,
    output logic [qslc_pkg::COUNT_W-1:0]    o_swaps
);

    logic [qslc_pkg::COUNT_W-1:0] r_cmp;
    logic [qslc_pkg::COUNT_W-1:0] r_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cmp  <= '0;
            r_swap <= '0;
        end else begin
            if (i_cmd.cmp_inc && (r_cmp != qslc_pkg::COUNT_MAX)) begin
                r_cmp <= r_cmp + qslc_pkg::COUNT_W'(1);
            end
            if (i_cmd.swap_inc && (r_swap != qslc_pkg::COUNT_MAX)) begin
                r_swap <= r_swap + qslc_pkg::COUNT_W'(1);
            end
        end
    end

    assign o_comparisons = r_cmp;
    assign o_swaps       = r_swap;

endmodule

FILE: design/quicksort_lomuto_with_counts_unit.sv
// load: one cycle per input beat; ready is high only while loading
// sort: per range the pivot is read, each element compared with it and swapped if smaller, then
//   the pivot placed, on the two-read one-write element memory; N log N to N squared comparisons
// emit: each result is read from the store, registered and held until taken, then the next is read
// reset clears control state and counters; memories hold no reset value and get no clearing pass
module quicksort_lomuto_with_counts_unit #(
    parameter int MAX_ELEMENTS = qslc_pkg::MAX_ELEMENTS_DEF,
    parameter int DATA_WIDTH   = qslc_pkg::DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  qslc_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output qslc_pkg::t_out_beat  o_out_beat
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_POP, S_RANGE, S_PIVOT, S_SCAN, S_CMP, S_SWAP,
        S_PLACE, S_PLACE_WB, S_PUSH_LO, S_EMIT_RD, S_EMIT_WAIT, S_EMIT_HOLD
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [IDX_W-1:0]             r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]             r_j, n_j, r_slot, n_slot, r_k, n_k;
    logic signed [DATA_WIDTH-1:0] r_pivot, n_pivot;
    logic [DATA_WIDTH-1:0]        r_tmp, n_tmp;
    logic                         r_out_valid, n_out_valid;
    qslc_pkg::t_out_beat          r_out_beat, n_out_beat;

    logic [DATA_WIDTH-1:0]        r_store [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0]        r_rd_a, r_rd_b;
    logic                         w_we;
    logic [IDX_W-1:0]             w_waddr, w_ra, w_rb;
    logic [DATA_WIDTH-1:0]        w_wdata;

    logic signed [qslc_pkg::WIDE_W-1:0]   w_in_wide, w_out_wide;
    logic signed [DATA_WIDTH-1:0]         w_rd_a_s;
    logic [DATA_WIDTH-1:0]                w_in_data;
    logic [IDX_W:0]                       w_slot_x, w_lo_x, w_hi_x;

    qslc_pkg::t_stack_cmd         w_st_cmd;
    logic [IDX_W-1:0]             w_st_lo_in, w_st_hi_in, w_st_lo, w_st_hi;
    logic                         w_st_empty;
    qslc_pkg::t_count_cmd         w_cnt_cmd;
    logic [qslc_pkg::COUNT_W-1:0] w_cmp_total, w_swap_total;

    qslc_stack #(
        .DEPTH (MAX_ELEMENTS),
        .IDX_W (IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_st_cmd),
        .i_lo    (w_st_lo_in),
        .i_hi    (w_st_hi_in),
        .o_lo    (w_st_lo),
        .o_hi    (w_st_hi),
        .o_empty (w_st_empty)
    );

    qslc_counts u_counts (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cnt_cmd),
        .o_comparisons (w_cmp_total),
        .o_swaps       (w_swap_total)
    );

    assign w_in_wide  = qslc_pkg::WIDE_W'(i_in_beat.value);
    assign w_in_data  = w_in_wide[DATA_WIDTH-1:0];
    assign w_rd_a_s   = r_rd_a;
    assign w_out_wide = qslc_pkg::WIDE_W'(w_rd_a_s);
    assign w_slot_x   = (IDX_W+1)'(r_slot);
    assign w_lo_x     = (IDX_W+1)'(r_lo);
    assign w_hi_x     = (IDX_W+1)'(r_hi);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_slot      = r_slot;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_tmp       = r_tmp;
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = r_rd_a;
        w_ra        = r_j;
        w_rb        = r_slot;
        w_st_cmd    = '0;
        w_st_lo_in  = r_lo;
        w_st_hi_in  = r_hi;
        w_cnt_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IDX_W-1:0];
                        w_wdata = w_in_data;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in_beat.last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                w_cnt_cmd.clear = 1'b1;
                w_st_cmd.clear  = 1'b1;
                if (r_count < CNT_W'(2)) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    w_st_cmd.push = 1'b1;
                    w_st_lo_in    = '0;
                    w_st_hi_in    = IDX_W'(r_count - CNT_W'(1));
                    n_state       = S_POP;
                end
            end
            S_POP: begin
                if (w_st_empty) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    w_st_cmd.pop = 1'b1;
                    n_state      = S_RANGE;
                end
            end
            S_RANGE: begin
                n_lo   = w_st_lo;
                n_hi   = w_st_hi;
                n_j    = w_st_lo;
                n_slot = w_st_lo;
                w_ra   = w_st_hi;
                if (w_st_lo >= w_st_hi) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PIVOT;
                end
            end
            S_PIVOT: begin
                n_pivot = r_rd_a;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_j < r_hi) begin
                    n_state = S_CMP;
                end else begin
                    w_ra    = r_hi;
                    n_state = S_PLACE;
                end
            end
            S_CMP: begin
                w_cnt_cmd.cmp_inc = 1'b1;
                if (w_rd_a_s < r_pivot) begin
                    w_we               = 1'b1;
                    w_waddr            = r_slot;
                    w_wdata            = r_rd_a;
                    n_tmp              = r_rd_b;
                    w_cnt_cmd.swap_inc = 1'b1;
                    n_state            = S_SWAP;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_tmp;
                n_slot  = r_slot + IDX_W'(1);
                n_j     = r_j + IDX_W'(1);
                n_state = S_SCAN;
            end
            S_PLACE: begin
                w_we               = 1'b1;
                w_waddr            = r_slot;
                w_wdata            = r_rd_a;
                n_tmp              = r_rd_b;
                w_cnt_cmd.swap_inc = 1'b1;
                n_state            = S_PLACE_WB;
            end
            S_PLACE_WB: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = r_tmp;
                if ((w_slot_x + (IDX_W+1)'(1)) < w_hi_x) begin
                    w_st_cmd.push = 1'b1;
                    w_st_lo_in    = r_slot + IDX_W'(1);
                    w_st_hi_in    = r_hi;
                end
                n_state = S_PUSH_LO;
            end
            S_PUSH_LO: begin
                if (w_slot_x >= (w_lo_x + (IDX_W+1)'(2))) begin
                    w_st_cmd.push = 1'b1;
                    w_st_lo_in    = r_lo;
                    w_st_hi_in    = r_slot - IDX_W'(1);
                end
                n_state = S_POP;
            end
            S_EMIT_RD: begin
                w_ra    = r_k;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                n_out_valid             = 1'b1;
                n_out_beat.sorted_value = w_out_wide[qslc_pkg::VALUE_W-1:0];
                n_out_beat.end_of_set   = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
                n_out_beat.comparisons  = w_cmp_total;
                n_out_beat.swaps        = w_swap_total;
                n_state                 = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_beat.end_of_set) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        w_ra    = r_k + IDX_W'(1);
                        n_state = S_EMIT_WAIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_j        <= n_j;
        r_slot     <= n_slot;
        r_k        <= n_k;
        r_pivot    <= n_pivot;
        r_tmp      <= n_tmp;
        r_out_beat <= n_out_beat;
    end

    // element store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_store[w_ra];
        r_rd_b <= r_store[w_rb];
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result beat is pending");

    a_set_end_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_beat.end_of_set) |=> o_in_ready)
        else $error("no return to loading after the final beat");

    a_set_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_beat.end_of_set) |=> !o_in_ready)
        else $error("loading resumed before the final beat");

    a_counts_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_beat.end_of_set)
            |=> ##1 (o_out_beat.swaps == $past(o_out_beat.swaps, 2)))
        else $error("swap total changed within a set");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for the quicksort unit: signed sets in, sorted beats and counts checked
module tb_top;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 260;
    localparam int CALM_TAIL    = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic signed [qslc_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [qslc_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {
        STYLE_WIDE,
        STYLE_NARROW,
        STYLE_EDGE,
        STYLE_RISING,
        STYLE_FALLING
    } t_value_style;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    qslc_pkg::t_in_beat  in_beat   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    qslc_pkg::t_out_beat out_beat;

    logic signed [qslc_pkg::VALUE_W-1:0] set_store [CAPACITY];
    int unsigned         set_fill = 0;
    qslc_pkg::t_out_beat sorted_expect[$];
    qslc_pkg::t_in_beat  beats_to_send[$];

    int unsigned sets_sorted     = 0;
    int unsigned largest_set     = 0;
    int unsigned overflow_items  = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned errors          = 0;
    int unsigned cycle_count     = 0;
    int          in_hold         = 0;
    int          out_hold        = 0;

    quicksort_lomuto_with_counts_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void sort_set_and_expect();
        int lo_stack[$];
        int hi_stack[$];
        int lo, hi, j, slot, k;
        logic signed [qslc_pkg::VALUE_W-1:0] pivot, tmp;
        logic [qslc_pkg::COUNT_W-1:0] cmp_total, swap_total;
        qslc_pkg::t_out_beat res;
        cmp_total  = '0;
        swap_total = '0;
        if (set_fill >= 2) begin
            lo_stack.push_back(0);
            hi_stack.push_back(set_fill - 1);
        end
        while (lo_stack.size() > 0) begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            if (lo < hi) begin
                pivot = set_store[hi];
                slot  = lo;
                for (j = lo; j < hi; j++) begin
                    if (cmp_total != qslc_pkg::COUNT_MAX) cmp_total++;
                    if (set_store[j] < pivot) begin
                        tmp             = set_store[slot];
                        set_store[slot] = set_store[j];
                        set_store[j]    = tmp;
                        if (swap_total != qslc_pkg::COUNT_MAX) swap_total++;
                        slot++;
                    end
                end
                tmp             = set_store[slot];
                set_store[slot] = set_store[hi];
                set_store[hi]   = tmp;
                if (swap_total != qslc_pkg::COUNT_MAX) swap_total++;
                if (slot + 1 < hi) begin
                    lo_stack.push_back(slot + 1);
                    hi_stack.push_back(hi);
                end
                if (slot >= lo + 2) begin
                    lo_stack.push_back(lo);
                    hi_stack.push_back(slot - 1);
                end
            end
        end
        for (k = 0; k < set_fill; k++) begin
            res.sorted_value = set_store[k];
            res.end_of_set   = (k == set_fill - 1);
            res.comparisons  = cmp_total;
            res.swaps        = swap_total;
            sorted_expect.push_back(res);
        end
        sets_sorted++;
        if (set_fill > largest_set) largest_set = set_fill;
        set_fill = 0;
    endfunction

    function automatic void take_element(qslc_pkg::t_in_beat b);
        if (set_fill < CAPACITY) begin
            set_store[set_fill] = b.value;
            set_fill++;
        end else begin
            overflow_items++;
        end
        if (b.last) sort_set_and_expect();
    endfunction

    function automatic logic signed [qslc_pkg::VALUE_W-1:0] pick_value(t_value_style style);
        case (style)
            STYLE_NARROW: return $signed($urandom_range(0, 6)) - 3;
            STYLE_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_value(logic signed [qslc_pkg::VALUE_W-1:0] v,
                                        logic is_last);
        qslc_pkg::t_in_beat b;
        b.value = v;
        b.last  = is_last;
        beats_to_send.push_back(b);
    endfunction

    function automatic void queue_set(int n, t_value_style style);
        logic signed [qslc_pkg::VALUE_W-1:0] base, v;
        int step, k;
        base = $urandom;
        base = base >>> 2;
        step = $urandom_range(0, 1000);
        for (k = 0; k < n; k++) begin
            case (style)
                STYLE_RISING:  v = base + k * step;
                STYLE_FALLING: v = base - k * step;
                default:       v = pick_value(style);
            endcase
            queue_value(v, k == n - 1);
        end
    endfunction

    function automatic bit idling_allowed();
        return beats_to_send.size() >= CALM_TAIL;
    endfunction

    function automatic void note_mismatch(string what, qslc_pkg::t_out_beat want,
                                          qslc_pkg::t_out_beat got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: want %0d/%0b/%0d/%0d, got %0d/%0b/%0d/%0d",
                     $time, what, want.sorted_value, want.end_of_set, want.comparisons,
                     want.swaps, got.sorted_value, got.end_of_set, got.comparisons, got.swaps);
    endfunction

    always @(posedge clk) begin : in_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_hold > 0) begin
                in_hold--;
                in_valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                in_hold = $urandom_range(0, 15);
                in_valid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
                in_beat  <= beats_to_send.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : out_driver
        if (out_hold > 0) begin
            out_hold--;
            out_ready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
            out_hold = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : monitor
        qslc_pkg::t_out_beat want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                items_sent++;
                take_element(in_beat);
            end
            if (out_valid && out_ready) begin
                results_checked++;
                if (sorted_expect.size() == 0) begin
                    note_mismatch("unexpected result", '0, out_beat);
                end else begin
                    want = sorted_expect.pop_front();
                    if (out_beat.sorted_value !== want.sorted_value ||
                        out_beat.end_of_set !== want.end_of_set ||
                        out_beat.comparisons !== want.comparisons ||
                        out_beat.swaps !== want.swaps)
                        note_mismatch("mismatch", want, out_beat);
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int k, n, pick, random_items;
        t_value_style style;

        // single element, extremes, ordered, reversed, equal, pair
        queue_value(VAL_MIN, 1'b1);
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b0);
        queue_value(0, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(1, 1'b1);
        queue_value(-2, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(5, 1'b0);
        queue_value(9, 1'b1);
        queue_value(9, 1'b0);
        queue_value(5, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(-2, 1'b1);
        for (k = 0; k < 4; k++) queue_value(7, k == 3);
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b1);
        queue_value(VAL_MAX, 1'b1);

        // a full store in reverse order, then a set that runs past capacity
        queue_set(CAPACITY, STYLE_FALLING);
        queue_set(CAPACITY + 3, STYLE_WIDE);
        random_items = 2 * CAPACITY + 3;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) n = $urandom_range(CAPACITY, CAPACITY + 4);
            else if (pick < 5) n = $urandom_range(13, 40);
            else n = $urandom_range(1, 12);
            style = t_value_style'($urandom_range(0, 4));
            queue_set(n, style);
            random_items += n;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (beats_to_send.size() > 0 || in_valid) @(posedge clk);
        while (sorted_expect.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d beats in %0d sets, largest %0d, %0d beats beyond capacity",
                 items_sent, sets_sorted, largest_set, overflow_items);
        $display("checked %0d sorted results, %0d errors", results_checked, errors);
        if (errors == 0 && sorted_expect.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
